// ===== hw/rtl/bor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename package
// Shared widths, constants, the queue word type, the sequencer states and a
// trailing-zero count used by the front and back parts.
// ----------------------------------------------------------------------------
package bor_pkg;

    localparam int WORD_W     = 32;
    localparam int OCC_W      = 64;
    localparam int BASE_W     = 20;
    localparam int CNT_W      = 7;
    localparam int ONES_W     = 6;
    localparam int MAX_W      = 19;
    localparam int LIM_W      = 13;
    localparam int LIMIT_ADD  = 63 + 1;
    localparam int LIMIT_CAP  = 4096;
    localparam int BASE_RESET = 1;
    localparam int TOP_BIT    = WORD_W - 1;
    localparam logic [MAX_W-1:0] MAX_SAT = '1;

    // One word as it travels from the front part to the back part.
    typedef struct packed {
        logic [WORD_W-1:0]       word;
        logic signed [CNT_W-1:0] cnt;
        logic                    nz;
        logic                    last;
        logic                    start;
    } t_work;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SLIDE,
        BS_DRAIN,
        BS_MERGE,
        BS_PACK,
        BS_EMIT
    } t_back_state;

    // Trailing-zero count of a 32-bit word as a five-step binary search.
    // An all-zero word counts as 32.
    function automatic logic [ONES_W-1:0] ctz32(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] x;
        logic [ONES_W-1:0] n;
        x = v;
        n = '0;
        if (v == '0) begin
            n = ONES_W'(WORD_W);
        end else begin
            if (x[15:0] == '0) begin
                n[4] = 1'b1;
                x    = x >> 16;
            end
            if (x[7:0] == '0) begin
                n[3] = 1'b1;
                x    = x >> 8;
            end
            if (x[3:0] == '0) begin
                n[2] = 1'b1;
                x    = x >> 4;
            end
            if (x[1:0] == '0) begin
                n[1] = 1'b1;
                x    = x >> 2;
            end
            if (x[0] == 1'b0) begin
                n[0] = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/bor_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename channels
// Valid/ready interfaces for the bitmap words in and the rename words out.
// ----------------------------------------------------------------------------
interface bor_in_if;
    import bor_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] bitmap_word;
    logic              last_word;
    logic              start_round;

    modport source (output valid, output bitmap_word, output last_word,
                    output start_round, input ready);
    modport sink   (input valid, input bitmap_word, input last_word,
                    input start_round, output ready);
endinterface

interface bor_out_if;
    import bor_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [BASE_W-1:0] rename_base;
    logic                     base_written;
    logic [MAX_W-1:0]         max_base;
    logic [LIM_W-1:0]         name_limit;

    modport source (output valid, output rename_base, output base_written,
                    output max_base, output name_limit, input ready);
    modport sink   (input valid, input rename_base, input base_written,
                    input max_base, input name_limit, output ready);
endinterface

// ===== hw/rtl/bitmap_overlap_rename_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename unit
// Gives each nonzero bitmap word a rename base by packing its set bits
// against a 64-bit occupancy shifter, and tracks the maximum base.
//
//   Channel  Dir  Fields
//   i_in     in   bitmap_word[31:0], last_word, start_round
//   o_out    out  rename_base[19:0] (signed), base_written, max_base[18:0],
//                 name_limit[12:0]
//
// A zero word goes from idle straight to emit. A nonzero word passes the
// slide steps, one place each, then drain steps if it still collides with
// its top bit set, then merge, pack and emit in the back sequencer.
// Reset is synchronous; the unit takes words from the first cycle after it.
// A two-word queue lets the input run ahead while the sequencer works, and
// a finished word waits in the output register while the next is packed.
// ----------------------------------------------------------------------------
module bitmap_overlap_rename_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bor_in_if.sink     i_in,
    bor_out_if.source  o_out
);
    import bor_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;
    t_work entry;
    t_work head;

    // Front part: accept and normalise.
    bor_front u_front (
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    // Queue between the two parts.
    bor_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    // Back part: pack and report.
    bor_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== hw/rtl/bor_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename front part
// Accepts bitmap words, classifies zero words and moves the set bits of a
// nonzero word down to bit 0, recording the shift as a negated offset.
// ----------------------------------------------------------------------------
module bor_front (
    bor_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output bor_pkg::t_work  o_entry
);
    import bor_pkg::*;

    logic [ONES_W-1:0] tz;

    // The input side is ready whenever the queue has a free slot.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Normalise the word and classify it.
    assign tz = ctz32(i_in.bitmap_word);

    always_comb begin
        o_entry.word  = i_in.bitmap_word >> tz[ONES_W-2:0];
        o_entry.cnt   = CNT_W'(-$signed({1'b0, tz}));
        o_entry.nz    = (i_in.bitmap_word != '0);
        o_entry.last  = i_in.last_word;
        o_entry.start = i_in.start_round;
    end

endmodule

// ===== hw/rtl/bor_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename queue
// Two-entry queue between the front and back parts so that each may stall
// on its own.
// ----------------------------------------------------------------------------
module bor_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bor_pkg::t_work  i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output bor_pkg::t_work  o_head,
    output logic            o_head_valid
);
    import bor_pkg::*;

    t_work      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/bor_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename back part
// Sequencer that slides each word against the occupancy shifter one place a
// cycle, drains the shifter on a collision, merges and packs, and keeps the
// running maximum. Results wait in an output register.
// ----------------------------------------------------------------------------
module bor_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bor_pkg::t_work  i_head,
    input  logic            i_head_valid,
    output logic            o_pop,
    bor_out_if.source       o_out
);
    import bor_pkg::*;

    t_back_state             r_state;
    t_back_state             n_state;
    logic [OCC_W-1:0]        r_occ;
    logic [BASE_W-1:0]       r_base;
    logic [BASE_W-1:0]       r_max;
    logic [WORD_W-1:0]       r_w;
    logic signed [CNT_W-1:0] r_cnt;
    logic                    r_last;
    logic                    r_nz;
    logic [BASE_W-1:0]       r_rb;
    logic [ONES_W-1:0]       r_ones;

    logic                    r_out_valid;
    logic [BASE_W-1:0]       r_o_rb;
    logic                    r_o_wr;
    logic [MAX_W-1:0]        r_o_max;
    logic [LIM_W-1:0]        r_o_lim;

    logic                    fits_slide;
    logic [OCC_W-1:0]        occ_dr;
    logic                    fits_drain;
    logic [OCC_W-1:0]        occ_m;
    logic                    out_free;
    logic                    out_load;
    logic [BASE_W-1:0]       n_max;
    logic [MAX_W-1:0]        max_sat;
    logic [LIM_W-1:0]        lim;

    // Collision checks against the low half of the shifter.
    assign fits_slide = ((r_occ[WORD_W-1:0] & r_w) == '0);
    assign occ_dr     = r_occ >> 1;
    assign fits_drain = ((occ_dr[WORD_W-1:0] & r_w) == '0);
    assign occ_m      = r_occ | {{(OCC_W-WORD_W){1'b0}}, r_w};

    // Running maximum and the result fields derived from it.
    assign out_free = !r_out_valid || o_out.ready;
    assign n_max    = (r_last && (r_base > r_max)) ? r_base : r_max;
    assign max_sat  = (n_max > BASE_W'(MAX_SAT)) ? MAX_SAT : n_max[MAX_W-1:0];
    assign lim      = (n_max > BASE_W'(LIMIT_CAP - LIMIT_ADD)) ? LIM_W'(LIMIT_CAP)
                      : LIM_W'(n_max[LIM_W-1:0] + LIM_W'(LIMIT_ADD));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_head_valid) begin
                    n_state = i_head.nz ? BS_SLIDE : BS_EMIT;
                end
            end
            BS_SLIDE: begin
                if (fits_slide) begin
                    n_state = BS_MERGE;
                end else if (r_w[TOP_BIT]) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: begin
                if (fits_drain) begin
                    n_state = BS_MERGE;
                end
            end
            BS_MERGE: n_state = BS_PACK;
            BS_PACK:  n_state = BS_EMIT;
            BS_EMIT: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_pop    = (r_state == BS_IDLE) && i_head_valid;
        out_load = (r_state == BS_EMIT) && out_free;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Packing state: shifter, base and running maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_base <= BASE_W'(BASE_RESET);
            r_max  <= '0;
        end else begin
            unique case (r_state)
                BS_IDLE: begin
                    if (o_pop && i_head.start) begin
                        r_max <= '0;
                    end
                end
                BS_DRAIN: begin
                    r_occ  <= occ_dr;
                    r_base <= r_base + BASE_W'(1);
                end
                BS_MERGE: begin
                    r_occ <= occ_m;
                end
                BS_PACK: begin
                    r_occ  <= r_occ >> r_ones;
                    r_base <= r_base + BASE_W'(r_ones);
                end
                BS_EMIT: begin
                    if (out_load && r_last) begin
                        r_max  <= n_max;
                        r_occ  <= '0;
                        r_base <= BASE_W'(BASE_RESET);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working word, offset and merge results.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_w    <= i_head.word;
            r_cnt  <= i_head.cnt;
            r_last <= i_head.last;
            r_nz   <= i_head.nz;
        end else if (r_state == BS_SLIDE && !fits_slide && !r_w[TOP_BIT]) begin
            r_w   <= r_w << 1;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_state == BS_MERGE) begin
            r_rb   <= r_base + {{(BASE_W-CNT_W){r_cnt[CNT_W-1]}}, r_cnt};
            r_ones <= ctz32(~occ_m[WORD_W-1:0]);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_rb  <= r_nz ? r_rb : '0;
            r_o_wr  <= r_nz;
            r_o_max <= max_sat;
            r_o_lim <= lim;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.rename_base  = $signed(r_o_rb);
    assign o_out.base_written = r_o_wr;
    assign o_out.max_base     = r_o_max;
    assign o_out.name_limit   = r_o_lim;

`ifndef ASSERT_OFF
    // A word entering the slide phase has been normalised to bit 0.
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SLIDE && $past(r_state) == BS_IDLE) |-> r_w[0])
        else $error("unnormalised word entered the slide phase");

    // Each slide step moves the word up by one; check that it is counted.
    a_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SLIDE && !fits_slide && !r_w[TOP_BIT])
        |=> (r_cnt == CNT_W'($past(r_cnt) + CNT_W'(1))))
        else $error("slide step lost the offset count");

    // Each drain step advances the base by one.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DRAIN) |=> (r_base == BASE_W'($past(r_base) + BASE_W'(1))))
        else $error("drain step did not advance the base");

    // A final word restarts the packing.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> (r_occ == '0 && r_base == BASE_W'(BASE_RESET)))
        else $error("packing not restarted after a final word");
`endif

endmodule

// ===== bench/bor_rename_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename checker
// Watches the bitmap word and rename word channels of the rename unit. Every
// accepted bitmap word is run through a local model of the packing shifter,
// the base counter and the running maximum, and the predicted rename word is
// queued. Every accepted rename word is compared field by field with the
// oldest queued prediction. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module bor_rename_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bor_in_if    i_words,
    bor_out_if   i_renames,
    output int   o_fail_count,
    output int   o_pending
);
    import bor_pkg::*;

    // One predicted rename word.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic              written;
        logic [MAX_W-1:0]  max;
        logic [LIM_W-1:0]  limit;
    } t_rename;

    // Model state: occupancy shifter, next base and running maximum.
    logic [OCC_W-1:0]  occ_shift;
    logic [BASE_W-1:0] base_next;
    logic [BASE_W-1:0] max_seen;

    t_rename pending_renames[$];
    t_rename predicted;
    t_rename seen;
    t_rename want;

    // Print a line for a mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] mismatch on %s: got 0x%0h, wanted 0x%0h",
                 $realtime, what, got, exp_val);
        o_fail_count = o_fail_count + 1;
    endtask

    // Pack one bitmap word against the shifter and work out its rename word.
    task automatic predict_rename(input logic [WORD_W-1:0] word_in,
                                  input logic last_in, input logic start_in,
                                  output t_rename r);
        logic [WORD_W-1:0]  w;
        logic [31:0]        tz;
        logic [31:0]        slide;
        logic [OCC_W-1:0]   w64;
        logic [BASE_W:0]    lim_sum;
        int                 ones;
        w         = word_in;
        r.base    = '0;
        r.written = 1'b0;
        if (start_in) begin
            max_seen = '0;
        end
        if (w != '0) begin
            // Move the set bits down to bit 0; the offset starts at minus the shift.
            tz = 0;
            while (!w[0]) begin
                w  = w >> 1;
                tz = tz + 1;
            end
            slide = 32'd0 - tz;
            // Slide upwards one place at a time until nothing collides or the top bit is set.
            w64 = {{(OCC_W-WORD_W){1'b0}}, w};
            while ((occ_shift & w64) != '0 && !w[TOP_BIT]) begin
                w     = w << 1;
                slide = slide + 1;
                w64   = {{(OCC_W-WORD_W){1'b0}}, w};
            end
            // Still colliding at the top: drain the shifter instead.
            if ((occ_shift & w64) != '0) begin
                occ_shift = occ_shift >> 1;
                base_next = base_next + 1'b1;
                while ((occ_shift & w64) != '0) begin
                    occ_shift = occ_shift >> 1;
                    base_next = base_next + 1'b1;
                end
            end
            r.base    = slide[BASE_W-1:0] + base_next;
            r.written = 1'b1;
            // Merge, then shift out the filled low slots.
            occ_shift = occ_shift | w64;
            ones = 0;
            while (ones < WORD_W && occ_shift[ones]) begin
                ones = ones + 1;
            end
            occ_shift = occ_shift >> ones;
            base_next = base_next + BASE_W'(ones);
        end
        if (last_in) begin
            if (base_next > max_seen) begin
                max_seen = base_next;
            end
            occ_shift = '0;
            base_next = BASE_W'(BASE_RESET);
        end
        r.max   = (max_seen > MAX_SAT) ? MAX_SAT : max_seen[MAX_W-1:0];
        lim_sum = {1'b0, max_seen} + (BASE_W+1)'(LIMIT_ADD);
        if (lim_sum > LIMIT_CAP) begin
            lim_sum = (BASE_W+1)'(LIMIT_CAP);
        end
        r.limit = lim_sum[LIM_W-1:0];
    endtask

    // Compare rename words as they leave, then predict for words going in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            occ_shift    = '0;
            base_next    = BASE_W'(BASE_RESET);
            max_seen     = '0;
            o_fail_count = 0;
            pending_renames.delete();
            o_pending <= 0;
        end else begin
            if (i_renames.valid && i_renames.ready) begin
                seen.base    = i_renames.rename_base;
                seen.written = i_renames.base_written;
                seen.max     = i_renames.max_base;
                seen.limit   = i_renames.name_limit;
                if (pending_renames.size() == 0) begin
                    report_mismatch("unexpected rename word", seen.base, 0);
                end else begin
                    want = pending_renames.pop_front();
                    if (seen.base != want.base) begin
                        report_mismatch("rename_base", seen.base, want.base);
                    end
                    if (seen.written != want.written) begin
                        report_mismatch("base_written", seen.written, want.written);
                    end
                    if (seen.max != want.max) begin
                        report_mismatch("max_base", seen.max, want.max);
                    end
                    if (seen.limit != want.limit) begin
                        report_mismatch("name_limit", seen.limit, want.limit);
                    end
                end
            end
            if (i_words.valid && i_words.ready) begin
                predict_rename(i_words.bitmap_word, i_words.last_word,
                               i_words.start_round, predicted);
                pending_renames.push_back(predicted);
            end
            o_pending <= pending_renames.size();
        end
    end

endmodule

// ===== bench/tb_bitmap_overlap_rename_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap overlap rename unit testbench
// Drives bitmap words into the rename unit and takes its rename words, with
// random gaps on the sender and random stalls on the receiver. A short
// directed sequence covers the corner words, then random bitmaps of mixed
// density follow, then a burst of full words without idling pushes the
// name limit to its cap. The checker beside the unit predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_overlap_rename_unit;
    import bor_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_WORDS  = 700;
    localparam int BURST_RUN     = 130;
    localparam int TAIL_CYCLES   = 100;

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    logic stall_on;
    int   fail_count;
    int   pending_count;
    int   cycle_count;

    bor_in_if  word_ch ();
    bor_out_if rename_ch ();

    bitmap_overlap_rename_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_ch),
        .o_out   (rename_ch)
    );

    bor_rename_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_words      (word_ch),
        .i_renames    (rename_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one bitmap word after a random gap and hold it until accepted.
    // With no gap, valid simply stays high into the next word.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic lw,
                             input logic sr);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_ch.valid       <= 1'b1;
        word_ch.bitmap_word <= w;
        word_ch.last_word   <= lw;
        word_ch.start_round <= sr;
        do @(posedge i_clk); while (!word_ch.ready);
    endtask

    // Stop offering words, let one edge pass so the checker's count is
    // current, then wait until every predicted rename word has come out.
    task automatic wait_drained;
        word_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Rename word receiver: random stalls before each word.
    initial begin : rename_sink
        int stall;
        rename_ch.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            stall = stall_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                rename_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rename_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rename_ch.valid);
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int                n_random;
        int                next_mode;
        int                len;
        int                k;
        logic              new_round;
        logic              lw;
        logic              sr;
        logic [WORD_W-1:0] w;
        logic [63:0]       run;

        word_ch.valid       <= 1'b0;
        word_ch.bitmap_word <= '0;
        word_ch.last_word   <= 1'b0;
        word_ch.start_round <= 1'b0;
        i_rst_n             <= 1'b0;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: extremes, collisions, slides and drains.
        send_word(32'h0000_0000, 1'b0, 1'b1);   // zero word opening a round
        send_word(32'h0000_0001, 1'b0, 1'b0);
        send_word(32'h8000_0000, 1'b0, 1'b0);   // negative base
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);   // full low half
        send_word(32'hAAAA_AAAA, 1'b0, 1'b0);
        send_word(32'h5555_5555, 1'b0, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b1, 1'b0);   // last word of a bitmap
        send_word(32'h8000_0001, 1'b0, 1'b0);
        send_word(32'hC000_0001, 1'b0, 1'b0);   // collides with top bit set: drain
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);   // long drain
        send_word(32'hFFFF_FFFE, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b0);   // zero word closing a bitmap
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h0000_F00F, 1'b1, 1'b1);   // start and last together
        send_word(32'h0000_0003, 1'b0, 1'b1);   // start on the first word of a bitmap
        send_word(32'hFFFF_0000, 1'b1, 1'b0);
        wait_drained();

        // Random bitmaps, mostly well formed, in stretches of varied idling.
        n_random  = 0;
        next_mode = 0;
        while (n_random < RANDOM_WORDS) begin
            if (n_random >= next_mode) begin
                case ($urandom_range(0, 3))
                    0: begin idle_on = 1'b1; stall_on = 1'b1; end
                    1: begin idle_on = 1'b1; stall_on = 1'b0; end
                    2: begin idle_on = 1'b0; stall_on = 1'b1; end
                    default: begin idle_on = 1'b0; stall_on = 1'b0; end
                endcase
                if ($urandom_range(0, 2) == 0) begin
                    wait_drained();
                end
                next_mode = next_mode + 60;
            end
            len       = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
            new_round = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0: w = '0;
                    1: w = '1;
                    2: w = 32'h1 << $urandom_range(0, 31);
                    3, 4: w = $urandom & $urandom & $urandom;
                    5: w = $urandom | $urandom;
                    6: begin
                        run = (64'h1 << $urandom_range(1, 32)) - 64'h1;
                        run = run << $urandom_range(0, 31);
                        w   = run[WORD_W-1:0];
                    end
                    default: w = $urandom;
                endcase
                // Mostly well-formed bitmaps, with a stray last or start now
                // and then.
                lw = (k == len - 1) || ($urandom_range(0, 39) == 0);
                sr = (k == 0 && new_round) || ($urandom_range(0, 39) == 0);
                send_word(w, lw, sr);
                n_random = n_random + 1;
            end
        end
        wait_drained();

        // A burst of full words without idling: the bitmap closes with a
        // base high enough to hold the name limit at its cap.
        idle_on  = 1'b0;
        stall_on = 1'b0;
        for (k = 0; k < BURST_RUN; k++) begin
            send_word('1, k == BURST_RUN - 1, k == 0);
        end
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0001, 1'b1, 1'b0);

        // Drain and allow for any stray late word.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bor_pkg.sv
hw/rtl/bor_channels.sv
hw/rtl/bor_front.sv
hw/rtl/bor_queue.sv
hw/rtl/bor_back.sv
hw/rtl/bitmap_overlap_rename_unit.sv
bench/bor_rename_checker.sv
bench/tb_bitmap_overlap_rename_unit.sv
